/* design/psc_pkg.sv */
`timescale 1ns / 1ps
// Package for the Pearson and Spearman correlation block.
// Holds the controller state type, the multiply select codes and the command and status structs.
package psc_pkg;

	localparam int COEF_W = 32;
	localparam int PCNT_W = 11;
	localparam int SRCH_W = 31;
	localparam int R_SHIFT = 62;
	localparam logic [SRCH_W-1:0] Q_ONE = 31'h4000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_INIT,
		ST_SUM_RD,
		ST_SUM_LD,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_CHECK,
		ST_SRCH,
		ST_FIN,
		ST_RK_INIT,
		ST_RK_RDI,
		ST_RK_KEY,
		ST_RK_SCAN,
		ST_RK_WR,
		ST_OUT
	} ctl_state_t;

	typedef enum logic [3:0] {
		MS_XX,
		MS_YY,
		MS_XY,
		MS_NXY,
		MS_SXY,
		MS_NXX,
		MS_SXX,
		MS_NYY,
		MS_SYY,
		MS_P,
		MS_R,
		MS_D,
		MS_DP
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     sums_clr;
		logic     idx_clr;
		logic     idx_inc;
		logic     sample_ld;
		logic     mul_go;
		mul_sel_t sel;
		logic     abs_c;
		logic     mid_set;
		logic     fin;
		logic     res_clr;
		logic     j_clr;
		logic     key_ld;
		logic     scan;
		logic     rank_wr;
		logic     spear;
		logic     rvar;
		logic     out_stb;
	} psc_cmd_t;

	typedef struct packed {
		logic n_small;
		logic idx_last;
		logic j_last;
		logic mul_done;
		logic var_ok;
		logic search_more;
	} psc_stat_t;

endpackage

/* design/psc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module psc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/psc_mul.sv */
`timescale 1ns / 1ps
// Shift-and-add signed multiplier that retires one bit of the second operand per cycle.
// Stops as soon as the remaining bits are zero; depends on nothing.
module psc_mul #(
	parameter int W = 236
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] prod
);

	logic         run_q;
	logic         done_q;
	logic         neg_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && b_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a[W-1] ? -a : a;
			b_q   <= b[W-1] ? -b : b;
			acc_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (run_q) begin
			if (b_q == '0) begin
				if (neg_q) begin
					acc_q <= -acc_q;
				end
			end else begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* design/psc_datapath.sv */
`timescale 1ns / 1ps
// Datapath: sample and rank stores, exact sums, shared multiplier, rank counters and root search.
// Depends on psc_pkg, psc_ram and psc_mul.
module psc_datapath
	import psc_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  psc_cmd_t                cmd,
	output psc_stat_t               stat,
	input  logic [SAMPLE_WIDTH-1:0] x_value,
	input  logic [SAMPLE_WIDTH-1:0] y_value,
	output logic [COEF_W-1:0]       pearson_coef,
	output logic                    pearson_valid,
	output logic [COEF_W-1:0]       spearman_coef,
	output logic                    spearman_valid,
	output logic [PCNT_W-1:0]       pair_count,
	output logic                    overflowed
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int RW = $clog2(2 * MAX_SAMPLES + 1);
	localparam int OW = (SW > RW) ? SW : RW + 1;
	localparam int W = 4 * OW + 4 * CW + 64;

	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     j_q;
	logic [CW-1:0]     less_q;
	logic [CW-1:0]     eq_q;
	logic [SW-1:0]     key_q;
	logic              full;
	logic [CW-1:0]     n_m1;
	logic [AW-1:0]     raddr;
	logic [SW-1:0]     x_rd;
	logic [SW-1:0]     y_rd;
	logic [RW-1:0]     xr_rd;
	logic [RW-1:0]     yr_rd;
	logic [SW-1:0]     cmp_rd;
	logic [RW-1:0]     rank_val;
	logic [W-1:0]      xa_d;
	logic [W-1:0]      xb_d;
	logic [W-1:0]      xa_q;
	logic [W-1:0]      xb_q;
	logic [W-1:0]      sa_q;
	logic [W-1:0]      sb_q;
	logic [W-1:0]      saa_q;
	logic [W-1:0]      sbb_q;
	logic [W-1:0]      sab_q;
	logic [W-1:0]      t_q;
	logic [W-1:0]      c_q;
	logic [W-1:0]      va_q;
	logic [W-1:0]      vb_q;
	logic [W-1:0]      p_q;
	logic [W-1:0]      r_q;
	logic              neg_q;
	logic [SRCH_W-1:0] lo_q;
	logic [SRCH_W-1:0] hi_q;
	logic [SRCH_W-1:0] mid_q;
	logic [SRCH_W:0]   d_val;
	logic [W-1:0]      n_ext;
	logic [W-1:0]      mul_a;
	logic [W-1:0]      mul_b;
	logic              mul_done;
	logic [W-1:0]      mul_prod;
	logic [COEF_W-1:0] lo_ext;
	logic [COEF_W-1:0] coef_val;
	logic              var_ok;
	logic [COEF_W-1:0] pc_q;
	logic              pv_q;
	logic [COEF_W-1:0] sc_q;
	logic              sv_q;

	assign full = (cnt_q == CW'(MAX_SAMPLES));
	assign n_m1 = cnt_q - CW'(1);
	assign raddr = (cmd.key_ld || cmd.scan) ? j_q + AW'(1) : idx_q;
	assign cmp_rd = cmd.rvar ? y_rd : x_rd;
	assign rank_val = RW'({less_q, 1'b0}) + RW'(eq_q) + RW'(1);

	psc_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_x_ram (
		.clk(clk), .we(cmd.load && !full), .waddr(cnt_q[AW-1:0]), .wdata(x_value),
		.raddr(raddr), .rdata(x_rd)
	);

	psc_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_y_ram (
		.clk(clk), .we(cmd.load && !full), .waddr(cnt_q[AW-1:0]), .wdata(y_value),
		.raddr(raddr), .rdata(y_rd)
	);

	psc_ram #(.WIDTH(RW), .DEPTH(MAX_SAMPLES)) u_xr_ram (
		.clk(clk), .we(cmd.rank_wr && !cmd.rvar), .waddr(idx_q), .wdata(rank_val),
		.raddr(raddr), .rdata(xr_rd)
	);

	psc_ram #(.WIDTH(RW), .DEPTH(MAX_SAMPLES)) u_yr_ram (
		.clk(clk), .we(cmd.rank_wr && cmd.rvar), .waddr(idx_q), .wdata(rank_val),
		.raddr(raddr), .rdata(yr_rd)
	);

	always_comb begin
		if (cmd.spear) begin
			xa_d = {{(W-RW){1'b0}}, xr_rd};
			xb_d = {{(W-RW){1'b0}}, yr_rd};
		end else begin
			xa_d = {{(W-SW){x_rd[SW-1]}}, x_rd};
			xb_d = {{(W-SW){y_rd[SW-1]}}, y_rd};
		end
	end

	assign n_ext = {{(W-CW){1'b0}}, cnt_q};
	assign d_val = {mid_q, 1'b0} - (SRCH_W+1)'(1);

	always_comb begin
		case (cmd.sel)
			MS_XX: begin
				mul_a = xa_q;
				mul_b = xa_q;
			end
			MS_YY: begin
				mul_a = xb_q;
				mul_b = xb_q;
			end
			MS_XY: begin
				mul_a = xb_q;
				mul_b = xa_q;
			end
			MS_NXY: begin
				mul_a = sab_q;
				mul_b = n_ext;
			end
			MS_SXY: begin
				mul_a = sa_q;
				mul_b = sb_q;
			end
			MS_NXX: begin
				mul_a = saa_q;
				mul_b = n_ext;
			end
			MS_SXX: begin
				mul_a = sa_q;
				mul_b = sa_q;
			end
			MS_NYY: begin
				mul_a = sbb_q;
				mul_b = n_ext;
			end
			MS_SYY: begin
				mul_a = sb_q;
				mul_b = sb_q;
			end
			MS_P: begin
				mul_a = va_q;
				mul_b = vb_q;
			end
			MS_R: begin
				mul_a = c_q;
				mul_b = c_q;
			end
			MS_D: begin
				mul_a = {{(W-SRCH_W-1){1'b0}}, d_val};
				mul_b = {{(W-SRCH_W-1){1'b0}}, d_val};
			end
			MS_DP: begin
				mul_a = p_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	psc_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_stb) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.j_clr) begin
			j_q <= '1;
		end else if (cmd.key_ld || cmd.scan) begin
			j_q <= j_q + AW'(1);
		end
		if (cmd.key_ld) begin
			key_q  <= cmp_rd;
			less_q <= '0;
			eq_q   <= '0;
		end else if (cmd.scan) begin
			if ($signed(cmp_rd) < $signed(key_q)) begin
				less_q <= less_q + CW'(1);
			end else if (cmp_rd == key_q) begin
				eq_q <= eq_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sums_clr) begin
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (cmd.sample_ld) begin
			xa_q <= xa_d;
			xb_q <= xb_d;
			sa_q <= sa_q + xa_d;
			sb_q <= sb_q + xb_d;
		end else if (mul_done) begin
			case (cmd.sel)
				MS_XX: saa_q <= saa_q + mul_prod;
				MS_YY: sbb_q <= sbb_q + mul_prod;
				MS_XY: sab_q <= sab_q + mul_prod;
				MS_NXY, MS_NXX, MS_NYY, MS_D: t_q <= mul_prod;
				MS_SXY: c_q <= t_q - mul_prod;
				MS_SXX: va_q <= t_q - mul_prod;
				MS_SYY: vb_q <= t_q - mul_prod;
				MS_P: p_q <= mul_prod;
				MS_R: r_q <= {mul_prod[W-R_SHIFT-1:0], {R_SHIFT{1'b0}}};
				MS_DP: begin
					if (mul_prod <= r_q) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - SRCH_W'(1);
					end
				end
				default: ;
			endcase
		end else if (cmd.abs_c) begin
			neg_q <= c_q[W-1];
			c_q   <= c_q[W-1] ? -c_q : c_q;
			lo_q  <= '0;
			hi_q  <= Q_ONE;
		end else if (cmd.mid_set) begin
			mid_q <= lo_q + ((hi_q - lo_q + SRCH_W'(1)) >> 1);
		end
	end

	assign var_ok = !va_q[W-1] && (va_q != '0) && !vb_q[W-1] && (vb_q != '0);
	assign lo_ext = {1'b0, lo_q};
	assign coef_val = !var_ok ? '0 : (neg_q ? -lo_ext : lo_ext);

	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			pc_q <= '0;
			pv_q <= 1'b0;
			sc_q <= '0;
			sv_q <= 1'b0;
		end else if (cmd.fin) begin
			if (cmd.spear) begin
				sc_q <= coef_val;
				sv_q <= var_ok;
			end else begin
				pc_q <= coef_val;
				pv_q <= var_ok;
			end
		end
	end

	assign stat.n_small     = (cnt_q < CW'(2));
	assign stat.idx_last    = (CW'(idx_q) == n_m1);
	assign stat.j_last      = (CW'(j_q) == n_m1);
	assign stat.mul_done    = mul_done;
	assign stat.var_ok      = var_ok;
	assign stat.search_more = (lo_q < hi_q);

	assign pearson_coef   = pc_q;
	assign pearson_valid  = pv_q;
	assign spearman_coef  = sc_q;
	assign spearman_valid = sv_q;
	assign pair_count     = PCNT_W'(cnt_q);
	assign overflowed     = ovf_q;

endmodule

/* design/psc_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences loading, summing, ranking and the root search.
// Depends on psc_pkg.
module psc_ctrl
	import psc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      last_pair,
	input  psc_stat_t stat,
	output logic      busy,
	output psc_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	mul_sel_t   sel_q, sel_d;
	logic       pass_q, pass_d;
	logic       rvar_q, rvar_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= MS_XX;
			pass_q  <= 1'b0;
			rvar_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			pass_q  <= pass_d;
			rvar_q  <= rvar_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		pass_d  = pass_q;
		rvar_d  = rvar_q;
		case (state_q)
			ST_IDLE: begin
				if (start && last_pair) begin
					pass_d  = 1'b0;
					rvar_d  = 1'b0;
					state_d = ST_SUM_INIT;
				end
			end
			ST_SUM_INIT: state_d = stat.n_small ? ST_OUT : ST_SUM_RD;
			ST_SUM_RD: state_d = ST_SUM_LD;
			ST_SUM_LD: begin
				sel_d   = MS_XX;
				state_d = ST_MUL_GO;
			end
			ST_MUL_GO: state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (stat.mul_done) begin
					state_d = ST_MUL_GO;
					case (sel_q)
						MS_XX: sel_d = MS_YY;
						MS_YY: sel_d = MS_XY;
						MS_XY: begin
							if (stat.idx_last) begin
								sel_d = MS_NXY;
							end else begin
								state_d = ST_SUM_RD;
							end
						end
						MS_NXY: sel_d = MS_SXY;
						MS_SXY: sel_d = MS_NXX;
						MS_NXX: sel_d = MS_SXX;
						MS_SXX: sel_d = MS_NYY;
						MS_NYY: sel_d = MS_SYY;
						MS_SYY: state_d = ST_CHECK;
						MS_P: sel_d = MS_R;
						MS_D: sel_d = MS_DP;
						MS_R, MS_DP: state_d = ST_SRCH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHECK: begin
				if (stat.var_ok) begin
					sel_d   = MS_P;
					state_d = ST_MUL_GO;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SRCH: begin
				if (stat.search_more) begin
					sel_d   = MS_D;
					state_d = ST_MUL_GO;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = pass_q ? ST_OUT : ST_RK_INIT;
			ST_RK_INIT: state_d = ST_RK_RDI;
			ST_RK_RDI: state_d = ST_RK_KEY;
			ST_RK_KEY: state_d = ST_RK_SCAN;
			ST_RK_SCAN: begin
				if (stat.j_last) begin
					state_d = ST_RK_WR;
				end
			end
			ST_RK_WR: begin
				if (!stat.idx_last) begin
					state_d = ST_RK_RDI;
				end else if (!rvar_q) begin
					rvar_d  = 1'b1;
					state_d = ST_RK_INIT;
				end else begin
					pass_d  = 1'b1;
					state_d = ST_SUM_INIT;
				end
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.sel   = sel_q;
		cmd.spear = pass_q;
		cmd.rvar  = rvar_q;
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_SUM_INIT: begin
				cmd.sums_clr = 1'b1;
				cmd.idx_clr  = 1'b1;
				cmd.res_clr  = !pass_q;
			end
			ST_SUM_LD: cmd.sample_ld = 1'b1;
			ST_MUL_GO: cmd.mul_go = 1'b1;
			ST_MUL_WAIT: cmd.idx_inc = stat.mul_done && (sel_q == MS_XY) && !stat.idx_last;
			ST_CHECK: cmd.abs_c = stat.var_ok;
			ST_SRCH: cmd.mid_set = stat.search_more;
			ST_FIN: cmd.fin = 1'b1;
			ST_RK_INIT: cmd.idx_clr = 1'b1;
			ST_RK_RDI: cmd.j_clr = 1'b1;
			ST_RK_KEY: cmd.key_ld = 1'b1;
			ST_RK_SCAN: cmd.scan = 1'b1;
			ST_RK_WR: begin
				cmd.rank_wr = 1'b1;
				cmd.idx_inc = !stat.idx_last;
			end
			ST_OUT: cmd.out_stb = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* design/pearson_spearman_correlation.sv */
`timescale 1ns / 1ps
// Top level of the Pearson and Spearman rank correlation block.
// Depends on psc_pkg, psc_ctrl and psc_datapath.
//
// Usage: a pair (x_value, y_value) is transferred at each rising edge where start is high
// and busy is low, one pair per cycle while loading. Pairs beyond MAX_SAMPLES are dropped
// and flagged in overflowed. A pair with last_pair set closes the set; busy then rises and
// the block computes both coefficients from the stored pairs.
// The result is shown for exactly one cycle with done high; the receiver cannot stall it.
// After done the pair count and overflow flag are cleared and busy falls.
// After the closing pair, each of the two summing passes takes three products per pair in
// the shift-and-add multiplier, plus up to eight further products; ranking runs a compare
// scan over the sample store for every pair, once for x and once for y; each root search
// takes at most 31 steps of two products. The shared serial multiplier and the single read
// port of the stores make these steps run one after another. Sets of fewer than two
// pairs skip the computation and finish with both valid flags low.
// Reset returns the controller to idle with an empty store.
module pearson_spearman_correlation
	import psc_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [SAMPLE_WIDTH-1:0] x_value,
	input  logic [SAMPLE_WIDTH-1:0] y_value,
	input  logic                    last_pair,
	output logic                    done,
	output logic [COEF_W-1:0]       pearson_coef,
	output logic                    pearson_valid,
	output logic [COEF_W-1:0]       spearman_coef,
	output logic                    spearman_valid,
	output logic [PCNT_W-1:0]       pair_count,
	output logic                    overflowed
);

	psc_cmd_t  cmd;
	psc_stat_t stat;

	psc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_pair(last_pair),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	psc_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.x_value(x_value), .y_value(y_value),
		.pearson_coef(pearson_coef), .pearson_valid(pearson_valid),
		.spearman_coef(spearman_coef), .spearman_valid(spearman_valid),
		.pair_count(pair_count), .overflowed(overflowed)
	);

	assign done = cmd.out_stb;

endmodule
